/* hdl/lcifs_pkg.sv */
// Shared types and constants for the LED color I2C frame sender.
// No dependencies; every other file in hdl/ refers to this package.

package lcifs_pkg;

    // Request function codes
    localparam logic [2:0] FUNC_SET_MODE    = 3'd0;
    localparam logic [2:0] FUNC_CYCLE_LEVEL = 3'd1;
    localparam logic [2:0] FUNC_SET_ARMED   = 3'd2;
    localparam logic [2:0] FUNC_BUS_DONE    = 3'd3;
    localparam logic [2:0] FUNC_TICK        = 3'd4;
    localparam logic [2:0] FUNC_REINIT      = 3'd5;

    // Bus commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    // Frame outcomes
    localparam logic [2:0] OUTCOME_BUSY          = 3'd0;
    localparam logic [2:0] OUTCOME_OK            = 3'd1;
    localparam logic [2:0] OUTCOME_START_TIMEOUT = 3'd2;
    localparam logic [2:0] OUTCOME_START_BAD     = 3'd3;
    localparam logic [2:0] OUTCOME_ADDR_TIMEOUT  = 3'd4;
    localparam logic [2:0] OUTCOME_ADDR_BAD      = 3'd5;
    localparam logic [2:0] OUTCOME_DATA_TIMEOUT  = 3'd6;
    localparam logic [2:0] OUTCOME_DATA_BAD      = 3'd7;

    // Bus status codes
    localparam logic [7:0] STATUS_MASK = 8'hF8;
    localparam logic [7:0] ST_START_OK = 8'h08;
    localparam logic [7:0] ST_ADDR_OK  = 8'h18;
    localparam logic [7:0] ST_DATA_OK  = 8'h28;

    // Configuration register indexes
    localparam logic CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd176;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd2000;
    localparam logic [15:0] WAIT_MAX            = 16'hFFFF;

    localparam logic [7:0] MODE_RESET  = 8'd0;
    localparam logic [2:0] LEVEL_RESET = 3'd2;
    localparam logic [2:0] LEVEL_MAX   = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_ADDR,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] value;
        logic [7:0] bus_status;
    } lcifs_in_t;

    typedef struct packed {
        logic [1:0] bus_command;
        logic [7:0] bus_byte;
        logic [2:0] outcome;
    } lcifs_out_t;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] mode_number;
        logic [2:0] brightness_level;
        logic       armed_flag;
    } settings_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } color_t;

    typedef struct packed {
        logic       has_result;
        lcifs_out_t result;
    } step_t;

endpackage

/* hdl/led_color_i2c_frame_sender.sv */
// A request is held in an input register and its result in a result register.
// Throughput: one request per cycle while not stalled; a request that yields no result still takes one slot.
// The input side stalls only while a result is held and the output side stalls.
// Reset (rst_n low, asynchronous): idle, mode 0, brightness level 2, armed, nothing pending,
// slave address 176, timeout 2000 ticks. The configuration port is always ready.
// Depends on lcifs_pkg and lcifs_ctrl.

module led_color_i2c_frame_sender
#(
    parameter int LED_COUNT = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lcifs_pkg::lcifs_in_t  in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lcifs_pkg::lcifs_out_t out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    lcifs_pkg::lcifs_in_t  in_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    lcifs_pkg::lcifs_out_t out_item_reg;
    lcifs_pkg::cfg_t       cfg_reg;
    lcifs_pkg::cfg_t       cfg_next;
    logic                  proc;
    lcifs_pkg::step_t      step;

    // Process the held request whenever the result register is free or draining
    assign proc      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    lcifs_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .enable (proc),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .step   (step)
    );

    always_comb
    begin
        in_valid_next = in_stall ? 1'b1 : in_valid;

        if (proc)
        begin
            out_valid_next = step.has_result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcifs_pkg::CFG_SLAVE_ADDRESS: cfg_next.slave_address = cfg_data[7:0];
                lcifs_pkg::CFG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{slave_address: lcifs_pkg::SLAVE_ADDRESS_RESET,
                               timeout_ticks: lcifs_pkg::TIMEOUT_TICKS_RESET};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_item_reg <= in_item;
        end
        if (proc && step.has_result)
        begin
            out_item_reg <= step.result;
        end
    end

endmodule

/* hdl/lcifs_color.sv */
// Color renderer: maps mode, brightness level and armed flag to a scaled RGB color.
// Depends on lcifs_pkg.

module lcifs_color
(
    input  lcifs_pkg::settings_t settings,
    output lcifs_pkg::color_t    color
);

    logic [7:0]        scale;
    lcifs_pkg::color_t src;
    logic [15:0]       prod_r;
    logic [15:0]       prod_g;
    logic [15:0]       prod_b;

    always_comb
    begin
        case (settings.brightness_level)
            3'd0:    scale = 8'h10;
            3'd1:    scale = 8'h30;
            3'd2:    scale = 8'h60;
            3'd3:    scale = 8'hA0;
            3'd4:    scale = 8'hFF;
            default: scale = 8'h10;
        endcase
    end

    always_comb
    begin
        // Disarmed mode 0 shows amber instead of blue
        if (settings.mode_number == 8'd0 && !settings.armed_flag)
        begin
            src = '{r: 8'd80, g: 8'd30, b: 8'd0};
        end
        else
        begin
            case (settings.mode_number)
                8'd0:    src = '{r: 8'd0,  g: 8'd0,  b: 8'd80};
                8'd1:    src = '{r: 8'd0,  g: 8'd80, b: 8'd0};
                8'd2:    src = '{r: 8'd80, g: 8'd0,  b: 8'd60};
                default: src = '{r: 8'd0,  g: 8'd0,  b: 8'd0};
            endcase
        end
    end

    assign prod_r = {8'd0, src.r} * {8'd0, scale};
    assign prod_g = {8'd0, src.g} * {8'd0, scale};
    assign prod_b = {8'd0, src.b} * {8'd0, scale};

    assign color = '{r: prod_r[15:8], g: prod_g[15:8], b: prod_b[15:8]};

endmodule

/* hdl/lcifs_ctrl.sv */
// Frame sequencer: settings, latched frame color and the I2C write state machine.
// Depends on lcifs_pkg and lcifs_color.

module lcifs_ctrl
#(
    parameter int LED_COUNT = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enable,
    input  lcifs_pkg::lcifs_in_t item,
    input  lcifs_pkg::cfg_t      cfg,
    output lcifs_pkg::step_t     step
);

    localparam int TOTAL = 3 * LED_COUNT;
    localparam int IDX_W = $clog2(TOTAL + 1);
    localparam logic [IDX_W-1:0] TOTAL_IDX = IDX_W'(TOTAL);

    lcifs_pkg::phase_t    phase_reg;
    lcifs_pkg::phase_t    phase_next;
    lcifs_pkg::settings_t settings_reg;
    lcifs_pkg::settings_t settings_next;
    lcifs_pkg::color_t    color_reg;
    lcifs_pkg::color_t    color_next;
    lcifs_pkg::color_t    render_color;
    logic [IDX_W-1:0]     byte_index_reg;
    logic [IDX_W-1:0]     byte_index_next;
    logic [1:0]           chan_reg;
    logic [1:0]           chan_next;
    logic [15:0]          wait_reg;
    logic [15:0]          wait_next;
    logic                 pending_reg;
    logic                 pending_next;

    logic                 setting;
    logic                 start_frame;
    logic [7:0]           status;
    logic [IDX_W-1:0]     idx_inc;
    logic [1:0]           chan_inc;
    logic [15:0]          wait_inc;

    function automatic logic [7:0] pick_byte(lcifs_pkg::color_t c, logic [1:0] chan);
        logic [7:0] b;
        case (chan)
            2'd0:    b = c.r;
            2'd1:    b = c.g;
            2'd2:    b = c.b;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // Render from the updated settings so a setting shows in the frame it starts
    lcifs_color u_color
    (
        .settings (settings_next),
        .color    (render_color)
    );

    assign status   = item.bus_status & lcifs_pkg::STATUS_MASK;
    assign idx_inc  = byte_index_reg + IDX_W'(1);
    assign chan_inc = (chan_reg == 2'd2) ? 2'd0 : chan_reg + 2'd1;
    assign wait_inc = (wait_reg != lcifs_pkg::WAIT_MAX) ? wait_reg + 16'd1 : wait_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lcifs_pkg::PH_IDLE;
            settings_reg   <= '{mode_number:      lcifs_pkg::MODE_RESET,
                                brightness_level: lcifs_pkg::LEVEL_RESET,
                                armed_flag:       1'b1};
            color_reg      <= '0;
            byte_index_reg <= '0;
            chan_reg       <= '0;
            wait_reg       <= '0;
            pending_reg    <= 1'b0;
        end
        else if (enable)
        begin
            phase_reg      <= phase_next;
            settings_reg   <= settings_next;
            color_reg      <= color_next;
            byte_index_reg <= byte_index_next;
            chan_reg       <= chan_next;
            wait_reg       <= wait_next;
            pending_reg    <= pending_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        settings_next   = settings_reg;
        color_next      = color_reg;
        byte_index_next = byte_index_reg;
        chan_next       = chan_reg;
        wait_next       = wait_reg;
        pending_next    = pending_reg;
        setting         = 1'b0;
        start_frame     = 1'b0;
        step            = '{has_result: 1'b0,
                            result: '{bus_command: lcifs_pkg::CMD_NONE,
                                      bus_byte:    8'd0,
                                      outcome:     lcifs_pkg::OUTCOME_BUSY}};

        case (item.func)
            lcifs_pkg::FUNC_SET_MODE:
            begin
                settings_next.mode_number = item.value;
                setting = 1'b1;
            end
            lcifs_pkg::FUNC_CYCLE_LEVEL:
            begin
                settings_next.brightness_level =
                    (settings_reg.brightness_level < lcifs_pkg::LEVEL_MAX)
                    ? settings_reg.brightness_level + 3'd1 : 3'd0;
                setting = 1'b1;
            end
            lcifs_pkg::FUNC_SET_ARMED:
            begin
                settings_next.armed_flag = |item.value;
                setting = 1'b1;
            end
            lcifs_pkg::FUNC_REINIT:
            begin
                settings_next = '{mode_number:      lcifs_pkg::MODE_RESET,
                                  brightness_level: lcifs_pkg::LEVEL_RESET,
                                  armed_flag:       1'b1};
                setting = 1'b1;
            end
            lcifs_pkg::FUNC_BUS_DONE:
            begin
                wait_next = 16'd0;
                case (phase_reg)
                    lcifs_pkg::PH_START:
                    begin
                        step.has_result = 1'b1;
                        if (status != lcifs_pkg::ST_START_OK)
                        begin
                            phase_next = lcifs_pkg::PH_IDLE;
                            step.result.bus_command = lcifs_pkg::CMD_STOP;
                            step.result.outcome     = lcifs_pkg::OUTCOME_START_BAD;
                        end
                        else
                        begin
                            phase_next = lcifs_pkg::PH_ADDR;
                            step.result.bus_command = lcifs_pkg::CMD_BYTE;
                            step.result.bus_byte    = cfg.slave_address;
                        end
                    end
                    lcifs_pkg::PH_ADDR:
                    begin
                        step.has_result = 1'b1;
                        if (status != lcifs_pkg::ST_ADDR_OK)
                        begin
                            phase_next = lcifs_pkg::PH_IDLE;
                            step.result.bus_command = lcifs_pkg::CMD_STOP;
                            step.result.outcome     = lcifs_pkg::OUTCOME_ADDR_BAD;
                        end
                        else
                        begin
                            phase_next      = lcifs_pkg::PH_DATA;
                            byte_index_next = '0;
                            chan_next       = 2'd0;
                            step.result.bus_command = lcifs_pkg::CMD_BYTE;
                            step.result.bus_byte    = color_reg.r;
                        end
                    end
                    lcifs_pkg::PH_DATA:
                    begin
                        step.has_result = 1'b1;
                        if (status != lcifs_pkg::ST_DATA_OK)
                        begin
                            phase_next = lcifs_pkg::PH_IDLE;
                            step.result.bus_command = lcifs_pkg::CMD_STOP;
                            step.result.outcome     = lcifs_pkg::OUTCOME_DATA_BAD;
                        end
                        else
                        begin
                            byte_index_next = idx_inc;
                            chan_next       = chan_inc;
                            if (idx_inc < TOTAL_IDX)
                            begin
                                step.result.bus_command = lcifs_pkg::CMD_BYTE;
                                step.result.bus_byte    = pick_byte(color_reg, chan_inc);
                            end
                            else
                            begin
                                phase_next = lcifs_pkg::PH_IDLE;
                                step.result.bus_command = lcifs_pkg::CMD_STOP;
                                step.result.outcome     = lcifs_pkg::OUTCOME_OK;
                            end
                        end
                    end
                    default:
                    begin
                        // Completion while idle: drop
                    end
                endcase
            end
            lcifs_pkg::FUNC_TICK:
            begin
                if (phase_reg == lcifs_pkg::PH_IDLE)
                begin
                    start_frame = pending_reg;
                end
                else
                begin
                    wait_next = wait_inc;
                    if (wait_inc >= cfg.timeout_ticks)
                    begin
                        phase_next = lcifs_pkg::PH_IDLE;
                        wait_next  = 16'd0;
                        step.has_result = 1'b1;
                        step.result.bus_command = lcifs_pkg::CMD_STOP;
                        case (phase_reg)
                            lcifs_pkg::PH_START:
                                step.result.outcome = lcifs_pkg::OUTCOME_START_TIMEOUT;
                            lcifs_pkg::PH_ADDR:
                                step.result.outcome = lcifs_pkg::OUTCOME_ADDR_TIMEOUT;
                            default:
                                step.result.outcome = lcifs_pkg::OUTCOME_DATA_TIMEOUT;
                        endcase
                    end
                end
            end
            default:
            begin
                // Unused codes: drop
            end
        endcase

        // A setting during a frame only marks one more frame to follow
        if (setting)
        begin
            if (phase_reg != lcifs_pkg::PH_IDLE)
            begin
                pending_next = 1'b1;
            end
            else
            begin
                start_frame = 1'b1;
            end
        end

        if (start_frame)
        begin
            color_next      = render_color;
            pending_next    = 1'b0;
            phase_next      = lcifs_pkg::PH_START;
            byte_index_next = '0;
            chan_next       = 2'd0;
            wait_next       = 16'd0;
            step.has_result = 1'b1;
            step.result.bus_command = lcifs_pkg::CMD_START;
            step.result.bus_byte    = 8'd0;
            step.result.outcome     = lcifs_pkg::OUTCOME_BUSY;
        end
    end

endmodule

/* hdl/lcifs_checker.sv */
// Port-level checks for the LED color I2C frame sender, bound to the top level.
// Depends on lcifs_pkg and led_color_i2c_frame_sender.

module lcifs_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input lcifs_pkg::lcifs_out_t out_item
);

    // Input back-pressure only comes from a held, stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed or dropped");

    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.bus_command != lcifs_pkg::CMD_NONE))
        else $error("result carries no bus command");

    a_outcome_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.bus_command != lcifs_pkg::CMD_STOP)
            |-> (out_item.outcome == lcifs_pkg::OUTCOME_BUSY))
        else $error("outcome set on a command other than STOP");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_item.bus_command == lcifs_pkg::CMD_START
                    || out_item.bus_command == lcifs_pkg::CMD_STOP))
            |-> (out_item.bus_byte == 8'd0))
        else $error("START or STOP carries a nonzero byte");

endmodule

bind led_color_i2c_frame_sender lcifs_checker u_lcifs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

/* dv/testbench.sv */
// Self-checking testbench for led_color_i2c_frame_sender: directed and random requests,
// with results compared against an in-bench prediction of the frame sender.
// Depends on lcifs_pkg and the RTL under hdl/.

module testbench;

    localparam int LEDS        = 4;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    localparam logic [7:0] MODE_BLUE    = 8'd0;
    localparam logic [7:0] MODE_GREEN   = 8'd1;
    localparam logic [7:0] MODE_MAGENTA = 8'd2;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    lcifs_pkg::lcifs_in_t  in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    lcifs_pkg::lcifs_out_t out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [15:0]           cfg_data  = '0;

    // Predicted block state
    logic [7:0]          pred_mode      = lcifs_pkg::MODE_RESET;
    logic [2:0]          cur_level      = lcifs_pkg::LEVEL_RESET;
    logic                pred_armed     = 1'b1;
    lcifs_pkg::color_t   latched_color  = '0;
    lcifs_pkg::phase_t   tx_phase       = lcifs_pkg::PH_IDLE;
    int                  sent_bytes     = 0;
    logic [15:0]         tick_count     = '0;
    logic                redraw_pending = 1'b0;
    logic [7:0]          addr_reg       = lcifs_pkg::SLAVE_ADDRESS_RESET;
    logic [15:0]         timeout_reg    = lcifs_pkg::TIMEOUT_TICKS_RESET;

    lcifs_pkg::lcifs_out_t expected_bus_ops[$];
    lcifs_pkg::lcifs_out_t next_expected;
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;
    bit                    quiet_phase    = 1'b0;
    int                    stall_hold     = 0;

    led_color_i2c_frame_sender #(.LED_COUNT(LEDS)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_idle_len();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------- prediction

    function automatic lcifs_pkg::step_t bus_op(logic [1:0] cmd, logic [7:0] data,
                                                logic [2:0] outcome);
        lcifs_pkg::step_t s;
        s.has_result         = 1'b1;
        s.result.bus_command = cmd;
        s.result.bus_byte    = data;
        s.result.outcome     = outcome;
        return s;
    endfunction

    function automatic logic [7:0] scale_channel(logic [7:0] ch, logic [7:0] scale);
        logic [15:0] prod;
        prod = {8'd0, ch} * {8'd0, scale};
        return prod[15:8];
    endfunction

    // Latch the color from the current settings and issue START
    function automatic lcifs_pkg::step_t start_frame();
        lcifs_pkg::color_t src;
        logic [7:0]        scale;
        case (cur_level)
            3'd1:    scale = 8'h30;
            3'd2:    scale = 8'h60;
            3'd3:    scale = 8'hA0;
            3'd4:    scale = 8'hFF;
            default: scale = 8'h10;
        endcase
        case (pred_mode)
            MODE_BLUE:    src = pred_armed ? {8'd0, 8'd0, 8'd80} : {8'd80, 8'd30, 8'd0};
            MODE_GREEN:   src = {8'd0, 8'd80, 8'd0};
            MODE_MAGENTA: src = {8'd80, 8'd0, 8'd60};
            default:      src = '0;
        endcase
        latched_color.r = scale_channel(src.r, scale);
        latched_color.g = scale_channel(src.g, scale);
        latched_color.b = scale_channel(src.b, scale);
        redraw_pending  = 1'b0;
        tx_phase        = lcifs_pkg::PH_START;
        sent_bytes      = 0;
        tick_count      = '0;
        return bus_op(lcifs_pkg::CMD_START, 8'h00, lcifs_pkg::OUTCOME_BUSY);
    endfunction

    function automatic lcifs_pkg::step_t end_frame(logic [2:0] outcome);
        tx_phase   = lcifs_pkg::PH_IDLE;
        tick_count = '0;
        return bus_op(lcifs_pkg::CMD_STOP, 8'h00, outcome);
    endfunction

    function automatic lcifs_pkg::step_t settle_settings();
        if (tx_phase != lcifs_pkg::PH_IDLE)
        begin
            redraw_pending = 1'b1;
            return '0;
        end
        return start_frame();
    endfunction

    function automatic logic [7:0] frame_byte(int idx);
        case (idx % 3)
            0:       return latched_color.r;
            1:       return latched_color.g;
            default: return latched_color.b;
        endcase
    endfunction

    function automatic lcifs_pkg::step_t advance_frame_sender(lcifs_pkg::lcifs_in_t req);
        lcifs_pkg::step_t s;
        logic [7:0]       st;
        s  = '0;
        st = req.bus_status & lcifs_pkg::STATUS_MASK;
        case (req.func)
            lcifs_pkg::FUNC_SET_MODE:
            begin
                pred_mode = req.value;
                s = settle_settings();
            end
            lcifs_pkg::FUNC_CYCLE_LEVEL:
            begin
                cur_level = (cur_level < lcifs_pkg::LEVEL_MAX) ? cur_level + 3'd1 : 3'd0;
                s = settle_settings();
            end
            lcifs_pkg::FUNC_SET_ARMED:
            begin
                pred_armed = (req.value != 8'h00);
                s = settle_settings();
            end
            lcifs_pkg::FUNC_REINIT:
            begin
                pred_mode  = lcifs_pkg::MODE_RESET;
                cur_level  = lcifs_pkg::LEVEL_RESET;
                pred_armed = 1'b1;
                s = settle_settings();
            end
            lcifs_pkg::FUNC_BUS_DONE:
            begin
                tick_count = '0;
                case (tx_phase)
                    lcifs_pkg::PH_START:
                        if (st != lcifs_pkg::ST_START_OK)
                            s = end_frame(lcifs_pkg::OUTCOME_START_BAD);
                        else
                        begin
                            tx_phase = lcifs_pkg::PH_ADDR;
                            s = bus_op(lcifs_pkg::CMD_BYTE, addr_reg, lcifs_pkg::OUTCOME_BUSY);
                        end
                    lcifs_pkg::PH_ADDR:
                        if (st != lcifs_pkg::ST_ADDR_OK)
                            s = end_frame(lcifs_pkg::OUTCOME_ADDR_BAD);
                        else
                        begin
                            tx_phase   = lcifs_pkg::PH_DATA;
                            sent_bytes = 0;
                            s = bus_op(lcifs_pkg::CMD_BYTE, frame_byte(0),
                                       lcifs_pkg::OUTCOME_BUSY);
                        end
                    lcifs_pkg::PH_DATA:
                        if (st != lcifs_pkg::ST_DATA_OK)
                            s = end_frame(lcifs_pkg::OUTCOME_DATA_BAD);
                        else
                        begin
                            sent_bytes++;
                            if (sent_bytes < 3 * LEDS)
                                s = bus_op(lcifs_pkg::CMD_BYTE, frame_byte(sent_bytes),
                                           lcifs_pkg::OUTCOME_BUSY);
                            else
                                s = end_frame(lcifs_pkg::OUTCOME_OK);
                        end
                    default: ;
                endcase
            end
            lcifs_pkg::FUNC_TICK:
            begin
                if (tx_phase == lcifs_pkg::PH_IDLE)
                begin
                    if (redraw_pending)
                        s = start_frame();
                end
                else
                begin
                    if (tick_count != lcifs_pkg::WAIT_MAX)
                        tick_count = tick_count + 16'd1;
                    if (tick_count >= timeout_reg)
                        case (tx_phase)
                            lcifs_pkg::PH_START:
                                s = end_frame(lcifs_pkg::OUTCOME_START_TIMEOUT);
                            lcifs_pkg::PH_ADDR:
                                s = end_frame(lcifs_pkg::OUTCOME_ADDR_TIMEOUT);
                            default:
                                s = end_frame(lcifs_pkg::OUTCOME_DATA_TIMEOUT);
                        endcase
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Enter right after an acceptance edge or at a point where in_valid may change
    task automatic put_request(logic [2:0] func, logic [7:0] value, logic [7:0] status);
        lcifs_pkg::lcifs_in_t req;
        int                   gap;
        lcifs_pkg::step_t     op;
        req.func       = func;
        req.value      = value;
        req.bus_status = status;
        gap = pick_idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        op = advance_frame_sender(req);
        if (op.has_result)
            expected_bus_ops.push_back(op.result);
    endtask

    task automatic write_register(logic idx, logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == lcifs_pkg::CFG_SLAVE_ADDRESS)
            addr_reg = data[7:0];
        else
            timeout_reg = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, then hold until every predicted result is back and the pipe is empty
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bus_ops.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] good_status();
        logic [7:0] base;
        case (tx_phase)
            lcifs_pkg::PH_START: base = lcifs_pkg::ST_START_OK;
            lcifs_pkg::PH_ADDR:  base = lcifs_pkg::ST_ADDR_OK;
            default:             base = lcifs_pkg::ST_DATA_OK;
        endcase
        return base | 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [2:0] pick_setting();
        case ($urandom_range(0, 3))
            0:       return lcifs_pkg::FUNC_SET_MODE;
            1:       return lcifs_pkg::FUNC_CYCLE_LEVEL;
            2:       return lcifs_pkg::FUNC_SET_ARMED;
            default: return lcifs_pkg::FUNC_REINIT;
        endcase
    endfunction

    // Mostly well-formed frames; some bad statuses, ticks, mid-frame settings and noise
    task automatic send_random_request(inout int counted);
        int         pick;
        logic [2:0] f;
        logic [7:0] v;
        logic [7:0] s;
        bit         ignored;
        pick = $urandom_range(0, 99);
        v    = 8'($urandom);
        s    = 8'($urandom);
        if (tx_phase == lcifs_pkg::PH_IDLE)
        begin
            if (pick < 70)
                f = pick_setting();
            else if (pick < 85)
                f = lcifs_pkg::FUNC_TICK;
            else if (pick < 92)
                f = lcifs_pkg::FUNC_BUS_DONE;
            else
                f = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
        end
        else
        begin
            if (pick < 72)
            begin
                f = lcifs_pkg::FUNC_BUS_DONE;
                s = good_status();
            end
            else if (pick < 78)
                f = lcifs_pkg::FUNC_BUS_DONE;
            else if (pick < 90)
                f = lcifs_pkg::FUNC_TICK;
            else if (pick < 97)
                f = pick_setting();
            else
                f = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
        end
        if (f == lcifs_pkg::FUNC_SET_MODE && $urandom_range(0, 3) != 0)
            v = 8'($urandom_range(0, 3));
        if (f == lcifs_pkg::FUNC_SET_ARMED && $urandom_range(0, 1) == 0)
            v = 8'h00;
        ignored = (f > lcifs_pkg::FUNC_REINIT) ||
                  (tx_phase == lcifs_pkg::PH_IDLE &&
                   (f == lcifs_pkg::FUNC_BUS_DONE ||
                    (f == lcifs_pkg::FUNC_TICK && !redraw_pending)));
        put_request(f, v, s);
        if (!ignored)
            counted++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_idle_requests();
        put_request(lcifs_pkg::FUNC_TICK, 8'hFF, 8'hFF);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, lcifs_pkg::ST_START_OK);
        put_request(FUNC_SPARE_LO, 8'hFF, 8'h00);
        put_request(FUNC_SPARE_HI, 8'h00, 8'hFF);
    endtask

    task automatic test_full_frame();
        put_request(lcifs_pkg::FUNC_SET_MODE, MODE_GREEN, 8'h00);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        // setting during the frame: held as pending, frame keeps its color
        put_request(lcifs_pkg::FUNC_CYCLE_LEVEL, 8'h00, 8'h00);
        while (tx_phase != lcifs_pkg::PH_IDLE)
            put_request(lcifs_pkg::FUNC_BUS_DONE, 8'($urandom), good_status());
        put_request(lcifs_pkg::FUNC_TICK, 8'h00, 8'h00);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'hFF, 8'h07);
    endtask

    task automatic test_bad_status();
        put_request(lcifs_pkg::FUNC_SET_MODE, 8'hFF, 8'h00);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, lcifs_pkg::ST_DATA_OK);
        put_request(lcifs_pkg::FUNC_SET_ARMED, 8'h00, 8'h00);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        put_request(lcifs_pkg::FUNC_SET_MODE, MODE_BLUE, 8'h00);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, 8'hFF);
        // a setting ahead of the tick starts the pending frame at once (amber)
        put_request(lcifs_pkg::FUNC_SET_ARMED, 8'h00, 8'h00);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, lcifs_pkg::ST_ADDR_OK);
    endtask

    task automatic test_timeouts();
        wait_for_results();
        write_register(lcifs_pkg::CFG_SLAVE_ADDRESS, 16'h0000);
        write_register(lcifs_pkg::CFG_TIMEOUT_TICKS, 16'd1);
        put_request(lcifs_pkg::FUNC_REINIT, 8'hFF, 8'h00);
        put_request(lcifs_pkg::FUNC_TICK, 8'h00, 8'h00);
        put_request(lcifs_pkg::FUNC_CYCLE_LEVEL, 8'h00, 8'h00);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        put_request(lcifs_pkg::FUNC_TICK, 8'h00, 8'h00);
        wait_for_results();
        write_register(lcifs_pkg::CFG_SLAVE_ADDRESS, 16'h00FF);
        write_register(lcifs_pkg::CFG_TIMEOUT_TICKS, 16'd0);
        put_request(lcifs_pkg::FUNC_CYCLE_LEVEL, 8'h00, 8'h00);
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        put_request(lcifs_pkg::FUNC_TICK, 8'h00, 8'h00);
        wait_for_results();
        write_register(lcifs_pkg::CFG_TIMEOUT_TICKS, 16'd3);
        put_request(lcifs_pkg::FUNC_CYCLE_LEVEL, 8'h00, 8'h00);
        repeat (2) put_request(lcifs_pkg::FUNC_TICK, 8'h00, 8'h00);
        // completion clears the tick count
        put_request(lcifs_pkg::FUNC_BUS_DONE, 8'h00, good_status());
        repeat (3) put_request(lcifs_pkg::FUNC_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_random_traffic();
        int          counted;
        logic [7:0]  addr;
        logic [15:0] ticks;
        for (int k = 0; k < 8; k++)
        begin
            wait_for_results();
            case (k % 3)
                0:       addr = 8'h00;
                1:       addr = 8'hFF;
                default: addr = 8'($urandom);
            endcase
            case (k % 4)
                0:       ticks = 16'd1;
                1:       ticks = 16'($urandom_range(2, 12));
                2:       ticks = 16'hFFFF;
                default: ticks = 16'($urandom_range(13, 2000));
            endcase
            write_register(lcifs_pkg::CFG_SLAVE_ADDRESS, {8'h00, addr});
            write_register(lcifs_pkg::CFG_TIMEOUT_TICKS, ticks);
            quiet_phase = (k % 3 == 1);
            counted = 0;
            while (counted < 60)
                send_random_request(counted);
        end
        quiet_phase = 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    always @(negedge clk)
    begin
        if (stall_hold > 0)
            stall_hold <= stall_hold - 1;
        else if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_hold <= pick_idle_len();
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bus_ops.size() == 0)
            begin
                $display("%0t unexpected result: expected none, got cmd %0d byte %0h out %0d",
                         $time, out_item.bus_command, out_item.bus_byte, out_item.outcome);
                mismatch_count++;
            end
            else
            begin
                next_expected = expected_bus_ops.pop_front();
                if (out_item.bus_command !== next_expected.bus_command)
                begin
                    $display("%0t bus_command: expected %0d, got %0d", $time,
                             next_expected.bus_command, out_item.bus_command);
                    mismatch_count++;
                end
                if (out_item.bus_byte !== next_expected.bus_byte)
                begin
                    $display("%0t bus_byte: expected %0h, got %0h", $time,
                             next_expected.bus_byte, out_item.bus_byte);
                    mismatch_count++;
                end
                if (out_item.outcome !== next_expected.outcome)
                begin
                    $display("%0t outcome: expected %0d, got %0d", $time,
                             next_expected.outcome, out_item.outcome);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_requests();
        test_full_frame();
        test_bad_status();
        test_timeouts();
        test_random_traffic();
        wait_for_results();
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
hdl/lcifs_pkg.sv
hdl/lcifs_color.sv
hdl/lcifs_ctrl.sv
hdl/led_color_i2c_frame_sender.sv
hdl/lcifs_checker.sv
dv/testbench.sv
